/* sv/sapt_pkg.sv */
package sapt_pkg;

    // Sizes of the selection list and of the index field.
    localparam int LIST_DEPTH  = 4096;
    localparam int INDEX_BITS  = 20;
    localparam int ADDR_W      = $clog2(LIST_DEPTH);
    localparam int COUNT_W     = $clog2(LIST_DEPTH + 1);

    // Coordinate and coefficient words.
    localparam int WORD_W      = 32;
    localparam int COEF_NUM    = 12;
    localparam int COEF_SEL_W  = 4;
    localparam int OPCODE_W    = 3;
    localparam int FRAC_SHIFT  = 24;

    // Accumulator holds three exact 64-bit products plus the rounding bias.
    localparam int PROD_W      = 2 * WORD_W;
    localparam int ACC_W       = PROD_W + 2;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_COEF   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POINT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REWIND = 3'd4;

    // One in Q8.24, the diagonal of the matrix after reset.
    localparam logic [WORD_W-1:0] ONE_Q24 = 32'h0100_0000;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [COEF_NUM-1:0] coef_bank_t;
    typedef word_t [2:0] vec3_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [INDEX_BITS-1:0] atom_index;
        logic [COEF_SEL_W-1:0] coef_select;
        logic signed [WORD_W-1:0] coef_value;
        logic signed [WORD_W-1:0] coord_x;
        logic signed [WORD_W-1:0] coord_y;
        logic signed [WORD_W-1:0] coord_z;
    } cmd_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] point_index;
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic                  was_transformed;
    } res_t;

endpackage

/* sv/sapt_stream_if.sv */
interface sapt_cmd_if;
    import sapt_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sapt_res_if;
    import sapt_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/sapt_affine_unit.sv */
module sapt_affine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sapt_pkg::vec3_t     coord,
    input  sapt_pkg::coef_bank_t coef,
    output logic                done,
    output sapt_pkg::vec3_t     res
);
    import sapt_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_ACC  = 2'd2;
    localparam logic [1:0] A_FIN  = 2'd3;

    // Accumulator starts at half an LSB of the result, which rounds half up.
    localparam logic signed [ACC_W-1:0] ACC_INIT =
        ACC_W'(1) <<< (FRAC_SHIFT - 1);

    logic [1:0] state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       done_reg, done_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    vec3_t res_reg;

    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [WORD_W-1:0] offset;
    logic signed [ACC_W-FRAC_SHIFT-1:0] scaled;
    logic signed [ACC_W-FRAC_SHIFT:0]   sum;
    logic [WORD_W-1:0] sat;

    // Operand selection for the single shared multiplier.
    always_comb
    begin
        mul_a  = $signed(coord[row_reg]);
        mul_b  = $signed(coef[4'(row_reg) * 4'd3 + 4'(col_reg)]);
        offset = $signed(coef[4'd9 + 4'(col_reg)]);
    end

    // Scale back to Q16.16, add the offset and saturate to 32 bits.
    always_comb
    begin
        scaled = acc_reg[ACC_W-1:FRAC_SHIFT];
        sum    = {scaled[ACC_W-FRAC_SHIFT-1], scaled}
               + {{(ACC_W-FRAC_SHIFT+1-WORD_W){offset[WORD_W-1]}}, offset};
        if (!sum[ACC_W-FRAC_SHIFT] && (|sum[ACC_W-FRAC_SHIFT-1:WORD_W-1]))
        begin
            sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (sum[ACC_W-FRAC_SHIFT] && !(&sum[ACC_W-FRAC_SHIFT-1:WORD_W-1]))
        begin
            sat = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            sat = sum[WORD_W-1:0];
        end
    end

    // Per column, A_MUL and A_ACC form and add three products, A_FIN ends it.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    acc_next   = ACC_INIT;
                    state_next = A_MUL;
                end
            end
            A_MUL:
            begin
                state_next = A_ACC;
            end
            A_ACC:
            begin
                acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                if (row_reg == 2'd2)
                begin
                    state_next = A_FIN;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = A_MUL;
                end
            end
            A_FIN:
            begin
                row_next = 2'd0;
                acc_next = ACC_INIT;
                if (col_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = A_MUL;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == A_MUL)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == A_FIN)
        begin
            res_reg[col_reg] <= sat;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* sv/selected_point_affine_transform_core.sv */
// Selected-point affine transform.
//
// Beats arrive on cmd and carry an opcode: clear the selection list, append
// an index, write one matrix coefficient, rewind the list pointer, or a point.
// Only a point beat produces a beat on result. Points must come in ascending
// atom index order against a sorted list; matching points are transformed
// as (x, y, z, 1) times the 4x3 matrix, others pass through unchanged.
//
// A non-point beat leaves cmd ready for the next beat. A point is accepted,
// then each list entry it examines takes a synchronous read of the list
// memory and a compare; the walk stops at the end of the list or at the
// first entry not below the index. On a match the shared multiplier unit
// forms three columns of three products plus a finishing step; then the
// output register is loaded. One item is in work at a time.
//
// Reset empties the list and restores the identity matrix with zero
// offsets. The result sits in an output register; while it is not taken,
// the block keeps accepting beats, and a finished point waits for the
// register to free up before cmd is ready again.
module selected_point_affine_transform_core (
    input  logic      clk,
    input  logic      rst_n,
    sapt_cmd_if.sink  cmd,
    sapt_res_if.source result
);
    import sapt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEEK  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_XFORM = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Identity linear part with zero offsets, entry 0 in the low word.
    localparam coef_bank_t COEF_RESET = {{(3*WORD_W){1'b0}}, ONE_Q24,
                                         {(3*WORD_W){1'b0}}, ONE_Q24,
                                         {(3*WORD_W){1'b0}}, ONE_Q24};

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  ptr_reg, ptr_next;
    logic                match_reg, match_next;
    logic [INDEX_BITS-1:0] idx_reg;
    vec3_t               coord_reg;
    coef_bank_t          coef_reg;
    logic                out_valid_reg;
    res_t                out_data_reg;

    logic [INDEX_BITS-1:0] list_mem [LIST_DEPTH];
    logic [INDEX_BITS-1:0] rd_data_reg;

    logic       accept;
    logic       mem_we;
    logic       emit;
    logic       xform_start;
    logic       xform_done;
    vec3_t      xres;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign mem_we    = accept && (cmd.data.opcode == OP_APPEND)
                     && (count_reg < COUNT_W'(LIST_DEPTH));
    assign emit      = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    // List memory: append writes at the fill count, reads follow the pointer.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            list_mem[count_reg[ADDR_W-1:0]] <= cmd.data.atom_index;
        end
        rd_data_reg <= list_mem[ptr_reg[ADDR_W-1:0]];
    end

    // Sequencer for list maintenance and the merge walk.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        match_next  = match_reg;
        xform_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.data.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ptr_next   = '0;
                        end
                        OP_APPEND:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_REWIND:
                        begin
                            ptr_next = '0;
                        end
                        OP_POINT:
                        begin
                            state_next = S_SEEK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEEK:
            begin
                // The memory reads the pointed entry during this cycle.
                if (ptr_reg < count_reg)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    match_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_CMP:
            begin
                if (rd_data_reg < idx_reg)
                begin
                    ptr_next   = ptr_reg + COUNT_W'(1);
                    state_next = S_SEEK;
                end
                else if (rd_data_reg == idx_reg)
                begin
                    ptr_next    = ptr_reg + COUNT_W'(1);
                    match_next  = 1'b1;
                    xform_start = 1'b1;
                    state_next  = S_XFORM;
                end
                else
                begin
                    match_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_XFORM:
            begin
                if (xform_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            match_reg <= match_next;
        end
    end

    // Matrix coefficients, identity after reset; bad selects are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (accept && (cmd.data.opcode == OP_COEF)
                 && (cmd.data.coef_select < COEF_SEL_W'(COEF_NUM)))
        begin
            coef_reg[cmd.data.coef_select] <= cmd.data.coef_value;
        end
    end

    // Point capture.
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.data.opcode == OP_POINT))
        begin
            idx_reg      <= cmd.data.atom_index;
            coord_reg[0] <= cmd.data.coord_x;
            coord_reg[1] <= cmd.data.coord_y;
            coord_reg[2] <= cmd.data.coord_z;
        end
    end

    sapt_affine_unit u_affine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (xform_start),
        .coord (coord_reg),
        .coef  (coef_reg),
        .done  (xform_done),
        .res   (xres)
    );

    // Output register, loaded once the previous beat has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.point_index     <= idx_reg;
            out_data_reg.out_x           <= match_reg ? xres[0] : coord_reg[0];
            out_data_reg.out_y           <= match_reg ? xres[1] : coord_reg[1];
            out_data_reg.out_z           <= match_reg ? xres[2] : coord_reg[2];
            out_data_reg.was_transformed <= match_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import sapt_pkg::*;

    localparam int IDX_MAX     = 2**INDEX_BITS - 1;
    localparam int MAT_COLS    = 3;
    localparam int OFFSET_BASE = 3 * MAT_COLS;
    localparam int QUIET_LIMIT = 50000;
    localparam int TAIL_CYCLES = 64;
    localparam int LONG_LIST   = 300;

    // Saturation bounds for the wide accumulator.
    localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
    localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

    logic clk = 1'b0;
    logic rst_n;

    sapt_cmd_if cmd_bus ();
    sapt_res_if res_bus ();

    selected_point_affine_transform_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (res_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the block's state: selection list, list pointer, matrix.
    logic [INDEX_BITS-1:0] sel_list [LIST_DEPTH];
    int                    sel_count;
    int                    sel_ptr;
    word_t                 coef_bank [COEF_NUM];

    res_t expected_points [$];
    int   mismatches    = 0;
    int   items_counted = 0;
    int   send_gap_pct  = 0;
    int   recv_gap_pct  = 0;
    int   quiet_cycles  = 0;

    function automatic int coef_at(input int row, input int col);
        return row * MAT_COLS + col;
    endfunction

    function automatic void reset_predictor();
        sel_count = 0;
        sel_ptr   = 0;
        foreach (coef_bank[k])
        begin
            coef_bank[k] = '0;
        end
        for (int d = 0; d < MAT_COLS; d++)
        begin
            coef_bank[coef_at(d, d)] = ONE_Q24;
        end
    endfunction

    // One output column: exact sum of products, round half up at 2^24,
    // add the Q16.16 offset, then clamp to 32 bits.
    function automatic word_t affine_column(input word_t x, input word_t y, input word_t z,
                                            input int col);
        logic signed [71:0] acc;
        logic signed [71:0] lhs;
        logic signed [71:0] rhs;
        word_t              crd [3];
        crd[0] = x;
        crd[1] = y;
        crd[2] = z;
        acc = 72'sd8388608;
        for (int i = 0; i < 3; i++)
        begin
            lhs = $signed(crd[i]);
            rhs = $signed(coef_bank[coef_at(i, col)]);
            acc = acc + lhs * rhs;
        end
        acc = acc >>> FRAC_SHIFT;
        rhs = $signed(coef_bank[OFFSET_BASE + col]);
        acc = acc + rhs;
        if (acc > SAT_HI)
            return 32'h7FFF_FFFF;
        if (acc < SAT_LO)
            return 32'h8000_0000;
        return acc[31:0];
    endfunction

    // Applies one accepted beat to the mirrored state; returns 1 when the
    // beat is a point, with the point's expected result in pt.
    function automatic bit apply_command(input cmd_t c, output res_t pt);
        logic [INDEX_BITS-1:0] idx;
        idx = c.atom_index;
        pt  = '0;
        case (c.opcode)
            OP_CLEAR:
            begin
                sel_count = 0;
                sel_ptr   = 0;
            end
            OP_APPEND:
            begin
                if (sel_count < LIST_DEPTH)
                begin
                    sel_list[sel_count] = idx;
                    sel_count++;
                end
            end
            OP_COEF:
            begin
                if (c.coef_select < COEF_NUM)
                    coef_bank[c.coef_select] = c.coef_value;
            end
            OP_REWIND:
            begin
                sel_ptr = 0;
            end
            OP_POINT:
            begin
                while (sel_ptr < sel_count && sel_list[sel_ptr] < idx)
                    sel_ptr++;
                pt.point_index = idx;
                if (sel_ptr < sel_count && sel_list[sel_ptr] == idx)
                begin
                    pt.out_x = affine_column(c.coord_x, c.coord_y, c.coord_z, 0);
                    pt.out_y = affine_column(c.coord_x, c.coord_y, c.coord_z, 1);
                    pt.out_z = affine_column(c.coord_x, c.coord_y, c.coord_z, 2);
                    pt.was_transformed = 1'b1;
                    sel_ptr++;
                end
                else
                begin
                    pt.out_x = c.coord_x;
                    pt.out_y = c.coord_y;
                    pt.out_z = c.coord_z;
                    pt.was_transformed = 1'b0;
                end
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // Random content in every field; callers then set what matters.
    function automatic cmd_t random_cmd(input logic [OPCODE_W-1:0] op);
        cmd_t c;
        c.opcode      = op;
        c.atom_index  = INDEX_BITS'($urandom_range(IDX_MAX));
        c.coef_select = COEF_SEL_W'($urandom_range(2**COEF_SEL_W - 1));
        c.coef_value  = $urandom;
        c.coord_x     = $urandom;
        c.coord_y     = $urandom;
        c.coord_z     = $urandom;
        return c;
    endfunction

    function automatic word_t pick_coord();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom_range(0, 2**25) - 2**24;
        endcase
    endfunction

    function automatic word_t pick_gain();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return ONE_Q24;
            2:       return '0;
            default: return $urandom_range(0, 2**26) - 2**25;
        endcase
    endfunction

    // Drives one beat at the falling edge, with random idle cycles before
    // it, and updates the prediction once the beat is taken.
    task automatic send_beat(input cmd_t c);
        res_t pt;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid = 1'b1;
        cmd_bus.data  = c;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        if (apply_command(c, pt))
            expected_points = {expected_points, pt};
        if (c.opcode <= OP_REWIND && !(c.opcode == OP_COEF && c.coef_select >= COEF_NUM))
            items_counted++;
    endtask

    task automatic send_op(input logic [OPCODE_W-1:0] op);
        send_beat(random_cmd(op));
    endtask

    task automatic send_append(input int idx);
        cmd_t c;
        c = random_cmd(OP_APPEND);
        c.atom_index = INDEX_BITS'(idx);
        send_beat(c);
    endtask

    task automatic send_coef(input int sel, input word_t val);
        cmd_t c;
        c = random_cmd(OP_COEF);
        c.coef_select = COEF_SEL_W'(sel);
        c.coef_value  = val;
        send_beat(c);
    endtask

    task automatic send_point(input int idx, input word_t x, input word_t y, input word_t z);
        cmd_t c;
        c = random_cmd(OP_POINT);
        c.atom_index = INDEX_BITS'(idx);
        c.coord_x    = x;
        c.coord_y    = y;
        c.coord_z    = z;
        send_beat(c);
    endtask

    // Holds the sender off until every expected point has come back.
    task automatic drain_results();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, every opcode, duplicates, repeats, out of order points,
    // rounding, saturation and ignored coefficient selects.
    task automatic test_directed();
        send_point(IDX_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        for (int op = OP_REWIND + 1; op < 2**OPCODE_W; op++)
        begin
            send_op(OPCODE_W'(op));
        end
        send_append(0);
        send_append(5);
        send_append(5);
        send_append(100);
        send_append(IDX_MAX);
        send_point(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_point(3, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(5, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_0000);
        send_point(5, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_0000);
        send_point(5, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_0000);
        send_point(4, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
        send_coef(coef_at(0, 0), 32'h7FFF_FFFF);
        send_coef(coef_at(1, 1), 32'h8000_0000);
        send_coef(coef_at(2, 2), 32'h0080_0000);
        send_coef(OFFSET_BASE, 32'h7FFF_FFFF);
        send_coef(OFFSET_BASE + 1, 32'h8000_0000);
        send_coef(OFFSET_BASE + 2, 32'h0001_0000);
        send_coef(COEF_NUM, 32'h5A5A_5A5A);
        send_coef(2**COEF_SEL_W - 1, 32'hA5A5_A5A5);
        // Saturates high, saturates low, and a half LSB that rounds up.
        send_point(100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
        // A negative half LSB rounds up to zero.
        send_point(IDX_MAX, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_op(OP_REWIND);
        send_point(100, 32'h0000_4000, 32'hFFFF_C000, 32'h0002_0000);
        send_op(OP_CLEAR);
        send_point(5, 32'h0000_0005, 32'h0000_0006, 32'h0000_0007);
    endtask

    // Builds a long list, then checks that the pointer can walk far along
    // it, including the top index values and a rewind across the whole list.
    task automatic test_long_list();
        int idx;
        int picks [$];
        send_op(OP_CLEAR);
        idx = $urandom_range(0, 200);
        repeat (LONG_LIST)
        begin
            send_append(idx);
            picks = {picks, idx};
            idx = idx + $urandom_range(0, 250);
        end
        send_append(IDX_MAX - 1);
        send_append(IDX_MAX);
        for (int k = 0; k < LONG_LIST; k += $urandom_range(10, 30))
        begin
            send_point(picks[k], pick_coord(), pick_coord(), pick_coord());
        end
        send_point(IDX_MAX - 1, pick_coord(), pick_coord(), pick_coord());
        send_point(IDX_MAX, pick_coord(), pick_coord(), pick_coord());
        send_op(OP_REWIND);
        send_point(IDX_MAX, pick_coord(), pick_coord(), pick_coord());
        send_op(OP_REWIND);
        send_point(picks[LONG_LIST - 1], pick_coord(), pick_coord(), pick_coord());
        drain_results();
    endtask

    // Mostly well-formed runs: clear, a few coefficients, a sorted list,
    // then ascending points that often hit the list. Noise is mixed in:
    // unused opcodes, rewinds, repeats, out of order points, unsorted lists.
    task automatic test_random_merge(input int target);
        int goal;
        int span;
        int npts;
        int prev;
        int idx;
        int j;
        int sel;
        int r;
        int a;
        int b;
        int tmp;
        int picks [$];
        goal = items_counted + target;
        while (items_counted < goal)
        begin
            picks.delete();
            if ($urandom_range(9) != 0)
                send_op(OP_CLEAR);
            repeat ($urandom_range(0, 4))
            begin
                sel = $urandom_range(2**COEF_SEL_W - 1);
                send_coef(sel, (sel < OFFSET_BASE) ? pick_gain() : pick_coord());
            end
            case ($urandom_range(2))
                0:       span = 3;
                1:       span = 300;
                default: span = 25000;
            endcase
            idx = $urandom_range(0, span);
            repeat ($urandom_range(0, 40))
            begin
                if (idx > IDX_MAX)
                    break;
                picks = {picks, idx};
                idx = idx + $urandom_range(0, span);
            end
            if (picks.size() > 1 && $urandom_range(19) == 0)
            begin
                a = $urandom_range(picks.size() - 1);
                b = $urandom_range(picks.size() - 1);
                tmp = picks[a];
                picks[a] = picks[b];
                picks[b] = tmp;
            end
            foreach (picks[k])
            begin
                send_append(picks[k]);
            end
            prev = 0;
            j = 0;
            npts = $urandom_range(1, 2 * picks.size() + 2);
            repeat (npts)
            begin
                r = $urandom_range(99);
                if (r < 3)
                begin
                    send_op(OPCODE_W'($urandom_range(OP_REWIND + 1, 2**OPCODE_W - 1)));
                end
                else if (r < 6)
                begin
                    send_op(OP_REWIND);
                    prev = 0;
                    j = 0;
                end
                else
                begin
                    if (r < 55 && j < picks.size())
                    begin
                        j = j + $urandom_range(0, 1);
                        if (j >= picks.size())
                            j = picks.size() - 1;
                        idx = picks[j];
                    end
                    else if (r < 90)
                        idx = prev + $urandom_range(0, span);
                    else if (r < 95)
                        idx = prev;
                    else
                        idx = $urandom_range(0, prev);
                    if (idx > IDX_MAX)
                        idx = IDX_MAX;
                    send_point(idx, pick_coord(), pick_coord(), pick_coord());
                    prev = idx;
                    while (j < picks.size() && picks[j] <= idx)
                        j++;
                end
            end
            if ($urandom_range(9) == 0)
                drain_results();
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Result side: random back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        res_bus.ready = ($urandom_range(99) >= recv_gap_pct);
    end

    // Each result beat is matched against the oldest expected point.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result beat, index %h", $time,
                         res_bus.data.point_index);
                mismatches++;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("point_index", 32'(want.point_index),
                            32'(res_bus.data.point_index));
                check_field("out_x", want.out_x, res_bus.data.out_x);
                check_field("out_y", want.out_y, res_bus.data.out_y);
                check_field("out_z", want.out_z, res_bus.data.out_z);
                check_field("was_transformed", 32'(want.was_transformed),
                            32'(res_bus.data.was_transformed));
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.data  = '0;
        res_bus.ready = 1'b0;
        reset_predictor();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Sender idles lightly while the receiver stalls often.
        send_gap_pct = 15;
        recv_gap_pct = 55;
        test_directed();
        drain_results();
        test_random_merge(350);
        drain_results();

        // Sender idles often while the receiver stalls lightly.
        send_gap_pct = 55;
        recv_gap_pct = 15;
        test_random_merge(350);
        drain_results();

        // Full throughput on both sides.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_long_list();
        test_random_merge(350);
        drain_results();

        // Let any late beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
